// File: rtl/core/rss_pkg.sv
// shared types, constants and helpers for the range segment splitter
package rss_pkg;

  localparam int unsigned SIZE_W    = 63;
  localparam int unsigned DELTA_W   = 24;
  localparam int unsigned SEG_IN_W  = 6;
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned KIND_W    = 3;
  localparam int unsigned REG_IDX_W = 4;

  typedef logic [SIZE_W-1:0] bytes_t;

  // size thresholds for the initial chunking
  localparam bytes_t ONE_MIB       = 63'd1048576;
  localparam bytes_t TEN_MIB       = 63'd10485760;
  localparam bytes_t HUNDRED_MIB   = 63'd104857600;
  localparam bytes_t MIN_SPLIT_RST = 63'd4194304;
  // end of the single segment when the size is unknown
  localparam bytes_t UNKNOWN_END   = 63'h4000_0000_0000_0000;

  localparam int unsigned CHUNKS_LOW  = 8;
  localparam int unsigned CHUNKS_MID  = 16;
  localparam int unsigned CHUNKS_HIGH = 32;
  localparam int unsigned SHIFT_LOW   = $clog2(CHUNKS_LOW);
  localparam int unsigned SHIFT_MID   = $clog2(CHUNKS_MID);
  localparam int unsigned SHIFT_HIGH  = $clog2(CHUNKS_HIGH);

  typedef enum logic [ACT_W-1:0] {
    ACT_BUILD    = 2'd0,
    ACT_PROGRESS = 2'd1,
    ACT_COMPLETE = 2'd2
  } action_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_BUILT    = 3'd0,
    KIND_PROGRESS = 3'd1,
    KIND_SPLIT    = 3'd2,
    KIND_NO_SPLIT = 3'd3,
    KIND_FULL     = 3'd4
  } kind_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FILE_SIZE   = 4'd0,
    REG_RANGES      = 4'd1,
    REG_SPLIT_EN    = 4'd2,
    REG_MIN_SPLIT   = 4'd3
  } reg_e;

  typedef struct packed {
    logic [ACT_W-1:0]    action;
    logic [SEG_IN_W-1:0] seg_index;
    logic [DELTA_W-1:0]  byte_delta;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [SEG_IN_W-1:0] seg_id;
    bytes_t              range_start;
    bytes_t              range_end;
    logic [SEG_IN_W-1:0] donor_id;
    bytes_t              total_done;
    logic                all_complete;
    logic                last;
  } result_t;

  // one table entry of the bounds memory
  typedef struct packed {
    bytes_t first;
    bytes_t last;
  } bounds_t;

  typedef struct packed {
    logic clear;
    logic push;
  } scan_ctl_t;

  typedef struct packed {
    logic   found;
    logic   busy;
    bytes_t best;
    bytes_t pos;
    bytes_t first;
    bytes_t last;
  } scan_res_t;

  function automatic bytes_t rss_sat_add(bytes_t a, bytes_t b);
    logic [SIZE_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[SIZE_W] ? '1 : sum[SIZE_W-1:0];
  endfunction

endpackage

// File: rtl/core/rss_if.sv
// handshake channels of the range segment splitter: items, results, register writes
interface rss_item_if;
  import rss_pkg::*;
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rss_result_if;
  import rss_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface rss_cfg_if;
  import rss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REG_IDX_W-1:0] index;
  bytes_t               value;
  modport source (output valid, output index, output value, input ready);
  modport sink (input valid, input index, input value, output ready);
endinterface

// File: rtl/core/rss_ram.sv
// generic single-port-write, single-port-read ram with registered read data
module rss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/rss_scan.sv
// pipelined search for the incomplete segment with the largest remainder
module rss_scan #(
  parameter int IDX_W = 6
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rss_pkg::scan_ctl_t  ctl_i,
  input  logic [IDX_W-1:0]    idx_i,
  input  rss_pkg::bytes_t     first_i,
  input  rss_pkg::bytes_t     last_i,
  input  rss_pkg::bytes_t     recv_i,
  output rss_pkg::scan_res_t  res_o,
  output logic [IDX_W-1:0]    donor_o
);
  import rss_pkg::*;

  // stage 1: segment length
  logic             s1_vld_q;
  logic [IDX_W-1:0] s1_idx_q;
  bytes_t           s1_first_q, s1_last_q, s1_recv_q, s1_len_q;
  // stage 2: remainder and resume point
  logic             s2_vld_q;
  logic [IDX_W-1:0] s2_idx_q;
  bytes_t           s2_rem_q, s2_pos_q, s2_first_q, s2_last_q;
  // running best
  logic             found_q;
  bytes_t           best_q;
  bytes_t           pos_q, dfirst_q, dlast_q;
  logic [IDX_W-1:0] donor_q;

  logic take;
  assign take = s2_vld_q && (s2_rem_q > best_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      found_q  <= 1'b0;
      best_q   <= '0;
    end else begin
      s1_vld_q <= ctl_i.push;
      s2_vld_q <= s1_vld_q && (s1_recv_q < s1_len_q);
      if (ctl_i.clear) begin
        found_q <= 1'b0;
        best_q  <= '0;
      end else if (take) begin
        found_q <= 1'b1;
        best_q  <= s2_rem_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q   <= idx_i;
    s1_first_q <= first_i;
    s1_last_q  <= last_i;
    s1_recv_q  <= recv_i;
    s1_len_q   <= last_i - first_i + bytes_t'(1);
    s2_idx_q   <= s1_idx_q;
    s2_rem_q   <= s1_len_q - s1_recv_q;
    s2_pos_q   <= s1_first_q + s1_recv_q;
    s2_first_q <= s1_first_q;
    s2_last_q  <= s1_last_q;
    if (take) begin
      pos_q    <= s2_pos_q;
      dfirst_q <= s2_first_q;
      dlast_q  <= s2_last_q;
      donor_q  <= s2_idx_q;
    end
  end

  always_comb begin
    res_o.found = found_q;
    res_o.busy  = s1_vld_q || s2_vld_q;
    res_o.best  = best_q;
    res_o.pos   = pos_q;
    res_o.first = dfirst_q;
    res_o.last  = dlast_q;
  end

  assign donor_o = donor_q;

endmodule

// File: rtl/core/range_segment_splitter_top.sv
// top level of the range segment splitter: control sequencer, segment table and result register
//
// The segment table (first byte, last byte, bytes received per segment) lives
// in two synchronous memories of MAX_SEGMENTS entries; entries are undefined
// until a build writes them, so there is no clearing pass after reset. Items
// are handled one at a time. A build emits 1, 8, 16 or 32 segments, each
// segment being a write to both memories and one result transfer. A
// progress item reads its entry, adds and writes back, then sends its
// result. A completion item skips the search when none is due (splitting
// off, ranges off, unknown size or empty table); otherwise the search for
// the largest remainder walks the table one entry a cycle through the
// memory read ports into a 3-stage compare pipeline. Results leave through
// an output register, so the next item can be taken while the last result
// still waits; a stalled result side holds the sequencer at its next
// result. Register writes are always taken.
module range_segment_splitter_top #(
  parameter int MAX_SEGMENTS = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rss_item_if.sink     in_ch_i,
  rss_result_if.source res_ch_o,
  rss_cfg_if.sink      cfg_ch_i
);
  import rss_pkg::*;

  localparam int IDX_W = $clog2(MAX_SEGMENTS);
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_BUILD  = 10'b00_0000_0010,
    ST_PRG_WB = 10'b00_0000_0100,
    ST_CMP_WB = 10'b00_0000_1000,
    ST_SCAN   = 10'b00_0001_0000,
    ST_DRAIN  = 10'b00_0010_0000,
    ST_DECIDE = 10'b00_0100_0000,
    ST_SPLIT  = 10'b00_1000_0000,
    ST_TAIL   = 10'b01_0000_0000,
    ST_EMIT   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;

  // configuration
  bytes_t file_size_q, min_split_q;
  logic   ranges_q, split_en_q;

  // table counters and running total
  logic [CNT_W-1:0] seg_count_q, seg_count_d;
  logic [CNT_W-1:0] done_count_q, done_count_d;
  bytes_t           total_q, total_d;

  // current item
  logic [SEG_IN_W-1:0] idx_q, idx_d;
  logic [DELTA_W-1:0]  delta_q, delta_d;
  logic                idx_ok_q, idx_ok_d;

  // build walk
  logic [IDX_W-1:0] bi_q, bi_d, nlast_q, nlast_d;
  bytes_t           start_q, start_d, chunk_q, chunk_d, chunk_m1_q, chunk_m1_d;
  bytes_t           tot_last_q, tot_last_d;

  // table scan
  logic [IDX_W-1:0] scan_i_q, scan_i_d, rd_idx_q;
  logic             rd_vld_q, rd_vld_d;
  bytes_t           mid_q, mid_d;

  // result being prepared
  kind_e               kind_q, kind_d;
  logic [SEG_IN_W-1:0] cur_id_q, cur_id_d, cur_donor_q, cur_donor_d;
  bytes_t              cur_start_q, cur_start_d, cur_end_q, cur_end_d;

  // output register
  logic    res_valid_q, res_valid_d;
  result_t res_q, res_d;

  // memory ports
  logic             b_we, b_re, r_we, r_re;
  logic [IDX_W-1:0] b_waddr, b_raddr, r_waddr, r_raddr;
  bounds_t          b_wdata, b_rdata;
  bytes_t           r_wdata, r_rdata;

  scan_ctl_t        scan_ctl;
  scan_res_t        scan_res;
  logic [IDX_W-1:0] scan_donor;

  // build set-up, taken from the registers at the transfer of a build item
  logic [CNT_W-1:0] nseg_w;
  bytes_t           chunk_w;

  logic   out_free, all_cmp, build_end, split_due, table_full;
  bytes_t build_last;

  assign in_ch_i.ready  = (state_q == ST_IDLE);
  assign cfg_ch_i.ready = 1'b1;
  assign res_ch_o.valid = res_valid_q;
  assign res_ch_o.data  = res_q;

  assign out_free   = !res_valid_q || res_ch_o.ready;
  assign all_cmp    = (seg_count_q != '0) && (done_count_q >= seg_count_q);
  assign build_end  = (bi_q == nlast_q);
  assign build_last = build_end ? tot_last_q : start_q + chunk_m1_q;
  // a split needs a remainder of at least the minimum and of two bytes
  assign split_due  = scan_res.found && (scan_res.best >= min_split_q) &&
                      (scan_res.best[SIZE_W-1:1] != '0);
  assign table_full = (seg_count_q == CNT_W'(MAX_SEGMENTS));

  // chunk count from the file size, one segment when ranges are off, size unknown or below 1 MiB
  always_comb begin
    nseg_w  = CNT_W'(1);
    chunk_w = file_size_q;
    if (ranges_q && (file_size_q != '0) && (file_size_q >= ONE_MIB)) begin
      if (file_size_q < TEN_MIB) begin
        nseg_w  = CNT_W'(CHUNKS_LOW);
        chunk_w = file_size_q >> SHIFT_LOW;
      end else if (file_size_q < HUNDRED_MIB) begin
        nseg_w  = CNT_W'(CHUNKS_MID);
        chunk_w = file_size_q >> SHIFT_MID;
      end else begin
        nseg_w  = CNT_W'(CHUNKS_HIGH);
        chunk_w = file_size_q >> SHIFT_HIGH;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    seg_count_d  = seg_count_q;
    done_count_d = done_count_q;
    total_d      = total_q;
    idx_d        = idx_q;
    delta_d      = delta_q;
    idx_ok_d     = idx_ok_q;
    bi_d         = bi_q;
    nlast_d      = nlast_q;
    start_d      = start_q;
    chunk_d      = chunk_q;
    chunk_m1_d   = chunk_m1_q;
    tot_last_d   = tot_last_q;
    scan_i_d     = scan_i_q;
    rd_vld_d     = 1'b0;
    mid_d        = mid_q;
    kind_d       = kind_q;
    cur_id_d     = cur_id_q;
    cur_donor_d  = cur_donor_q;
    cur_start_d  = cur_start_q;
    cur_end_d    = cur_end_q;
    res_d        = res_q;
    res_valid_d  = res_valid_q && !res_ch_o.ready;

    b_we     = 1'b0;
    b_waddr  = '0;
    b_wdata  = '0;
    b_re     = 1'b0;
    b_raddr  = '0;
    r_we     = 1'b0;
    r_waddr  = '0;
    r_wdata  = '0;
    r_re     = 1'b0;
    r_raddr  = '0;
    scan_ctl = '0;
    // read data of the previous scan cycle enters the compare pipeline
    scan_ctl.push = rd_vld_q;

    case (state_q)
      ST_IDLE: begin
        if (in_ch_i.valid) begin
          idx_d    = in_ch_i.data.seg_index;
          delta_d  = in_ch_i.data.byte_delta;
          idx_ok_d = CNT_W'(in_ch_i.data.seg_index) < seg_count_q;
          case (in_ch_i.data.action)
            ACT_BUILD: begin
              seg_count_d  = nseg_w;
              done_count_d = '0;
              total_d      = '0;
              bi_d         = '0;
              start_d      = '0;
              chunk_d      = chunk_w;
              chunk_m1_d   = chunk_w - bytes_t'(1);
              tot_last_d   = (file_size_q == '0) ? UNKNOWN_END : file_size_q - bytes_t'(1);
              nlast_d      = IDX_W'(nseg_w - CNT_W'(1));
              state_d      = ST_BUILD;
            end
            ACT_PROGRESS: begin
              total_d = rss_sat_add(total_q, bytes_t'(in_ch_i.data.byte_delta));
              b_re    = 1'b1;
              b_raddr = IDX_W'(in_ch_i.data.seg_index);
              r_re    = 1'b1;
              r_raddr = IDX_W'(in_ch_i.data.seg_index);
              state_d = ST_PRG_WB;
            end
            ACT_COMPLETE: begin
              // completions count even for a stale index or a repeat
              if (done_count_q < CNT_W'(MAX_SEGMENTS)) begin
                done_count_d = done_count_q + CNT_W'(1);
              end
              b_re    = 1'b1;
              b_raddr = IDX_W'(in_ch_i.data.seg_index);
              state_d = ST_CMP_WB;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      // one segment written and transferred per cycle while the result side is free
      ST_BUILD: begin
        if (out_free) begin
          b_we                     = 1'b1;
          b_waddr                  = bi_q;
          b_wdata.first            = start_q;
          b_wdata.last             = build_last;
          r_we                     = 1'b1;
          r_waddr                  = bi_q;
          r_wdata                  = '0;
          res_valid_d              = 1'b1;
          res_d.kind               = KIND_BUILT;
          res_d.seg_id             = SEG_IN_W'(bi_q);
          res_d.range_start        = start_q;
          res_d.range_end          = build_last;
          res_d.donor_id           = '0;
          res_d.total_done         = total_q;
          res_d.all_complete       = all_cmp;
          res_d.last               = build_end;
          bi_d                     = bi_q + IDX_W'(1);
          start_d                  = start_q + chunk_q;
          if (build_end) begin
            state_d = ST_IDLE;
          end
        end
      end

      ST_PRG_WB: begin
        kind_d      = KIND_PROGRESS;
        cur_id_d    = idx_q;
        cur_donor_d = '0;
        cur_start_d = '0;
        cur_end_d   = '0;
        if (idx_ok_q) begin
          r_we        = 1'b1;
          r_waddr     = IDX_W'(idx_q);
          r_wdata     = rss_sat_add(r_rdata, bytes_t'(delta_q));
          cur_start_d = b_rdata.first;
          cur_end_d   = b_rdata.last;
        end
        state_d = ST_EMIT;
      end

      // mark the segment full, then start the largest-remainder search when one is due
      ST_CMP_WB: begin
        kind_d         = KIND_NO_SPLIT;
        cur_id_d       = idx_q;
        cur_donor_d    = '0;
        cur_start_d    = '0;
        cur_end_d      = '0;
        scan_ctl.clear = 1'b1;
        scan_i_d       = '0;
        if (idx_ok_q) begin
          r_we        = 1'b1;
          r_waddr     = IDX_W'(idx_q);
          r_wdata     = b_rdata.last - b_rdata.first + bytes_t'(1);
          cur_start_d = b_rdata.first;
          cur_end_d   = b_rdata.last;
        end
        if (split_en_q && ranges_q && (file_size_q != '0) && (seg_count_q != '0)) begin
          state_d = ST_SCAN;
        end else begin
          state_d = ST_DECIDE;
        end
      end

      // one table entry read per cycle, data feeds the compare pipeline next cycle
      ST_SCAN: begin
        b_re     = 1'b1;
        b_raddr  = scan_i_q;
        r_re     = 1'b1;
        r_raddr  = scan_i_q;
        rd_vld_d = 1'b1;
        scan_i_d = scan_i_q + IDX_W'(1);
        if (scan_i_q == IDX_W'(seg_count_q - CNT_W'(1))) begin
          state_d = ST_DRAIN;
        end
      end

      ST_DRAIN: begin
        if (!rd_vld_q && !scan_res.busy) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        mid_d = scan_res.pos + (scan_res.best >> 1);
        if (split_due) begin
          if (table_full) begin
            kind_d      = KIND_FULL;
            cur_donor_d = SEG_IN_W'(scan_donor);
            state_d     = ST_EMIT;
          end else begin
            state_d = ST_SPLIT;
          end
        end else begin
          state_d = ST_EMIT;
        end
      end

      // donor keeps the head up to the split point; new tail starts empty
      ST_SPLIT: begin
        b_we          = 1'b1;
        b_waddr       = scan_donor;
        b_wdata.first = scan_res.first;
        b_wdata.last  = mid_q - bytes_t'(1);
        r_we          = 1'b1;
        r_waddr       = IDX_W'(seg_count_q);
        r_wdata       = '0;
        state_d       = ST_TAIL;
      end

      ST_TAIL: begin
        b_we          = 1'b1;
        b_waddr       = IDX_W'(seg_count_q);
        b_wdata.first = mid_q;
        b_wdata.last  = scan_res.last;
        seg_count_d   = seg_count_q + CNT_W'(1);
        kind_d        = KIND_SPLIT;
        cur_id_d      = SEG_IN_W'(seg_count_q);
        cur_start_d   = mid_q;
        cur_end_d     = scan_res.last;
        cur_donor_d   = SEG_IN_W'(scan_donor);
        state_d       = ST_EMIT;
      end

      ST_EMIT: begin
        if (out_free) begin
          res_valid_d        = 1'b1;
          res_d.kind         = kind_q;
          res_d.seg_id       = cur_id_q;
          res_d.range_start  = cur_start_q;
          res_d.range_end    = cur_end_q;
          res_d.donor_id     = cur_donor_q;
          res_d.total_done   = total_q;
          res_d.all_complete = all_cmp;
          res_d.last         = 1'b1;
          state_d            = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      seg_count_q  <= '0;
      done_count_q <= '0;
      total_q      <= '0;
      rd_vld_q     <= 1'b0;
      res_valid_q  <= 1'b0;
      file_size_q  <= '0;
      ranges_q     <= 1'b0;
      split_en_q   <= 1'b1;
      min_split_q  <= MIN_SPLIT_RST;
    end else begin
      state_q      <= state_d;
      seg_count_q  <= seg_count_d;
      done_count_q <= done_count_d;
      total_q      <= total_d;
      rd_vld_q     <= rd_vld_d;
      res_valid_q  <= res_valid_d;
      if (cfg_ch_i.valid) begin
        case (cfg_ch_i.index)
          REG_FILE_SIZE: file_size_q <= cfg_ch_i.value;
          REG_RANGES:    ranges_q    <= cfg_ch_i.value[0];
          REG_SPLIT_EN:  split_en_q  <= cfg_ch_i.value[0];
          REG_MIN_SPLIT: min_split_q <= cfg_ch_i.value;
          default: begin
            // writes beyond the register list are dropped
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    delta_q     <= delta_d;
    idx_ok_q    <= idx_ok_d;
    bi_q        <= bi_d;
    nlast_q     <= nlast_d;
    start_q     <= start_d;
    chunk_q     <= chunk_d;
    chunk_m1_q  <= chunk_m1_d;
    tot_last_q  <= tot_last_d;
    scan_i_q    <= scan_i_d;
    rd_idx_q    <= scan_i_q;
    mid_q       <= mid_d;
    kind_q      <= kind_d;
    cur_id_q    <= cur_id_d;
    cur_donor_q <= cur_donor_d;
    cur_start_q <= cur_start_d;
    cur_end_q   <= cur_end_d;
    res_q       <= res_d;
  end

  // segment bounds: first and last byte of each entry
  rss_ram #(
    .WIDTH($bits(bounds_t)),
    .DEPTH(MAX_SEGMENTS)
  ) u_bounds_ram (
    .clk_i   (clk_i),
    .we_i    (b_we),
    .waddr_i (b_waddr),
    .wdata_i (b_wdata),
    .re_i    (b_re),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  // bytes received per entry
  rss_ram #(
    .WIDTH(SIZE_W),
    .DEPTH(MAX_SEGMENTS)
  ) u_recv_ram (
    .clk_i   (clk_i),
    .we_i    (r_we),
    .waddr_i (r_waddr),
    .wdata_i (r_wdata),
    .re_i    (r_re),
    .raddr_i (r_raddr),
    .rdata_o (r_rdata)
  );

  rss_scan #(
    .IDX_W(IDX_W)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (scan_ctl),
    .idx_i   (rd_idx_q),
    .first_i (b_rdata.first),
    .last_i  (b_rdata.last),
    .recv_i  (r_rdata),
    .res_o   (scan_res),
    .donor_o (scan_donor)
  );

endmodule
